### rtl/lphm_pkg.sv
// Shared types and constants for the linear probing hash map.
// No dependencies; imported by every module of the block except lphm_ram.
`timescale 1ns / 1ps
package lphm_pkg;

  localparam int KEY_W            = 32;
  localparam int VAL_W            = 32;
  localparam int SIZE_W           = 10;
  localparam int STATUS_W         = 2;
  localparam int SLOT_OUT_W       = 9;
  localparam int DEFAULT_SLOTS    = 512;
  localparam int TABLE_SIZE_RESET = 512;

  // remainder unit retires this many key bits per cycle
  localparam int MOD_RADIX_BITS   = 4;
  localparam int MOD_STEPS        = KEY_W / MOD_RADIX_BITS;
  localparam int MOD_CNT_W        = $clog2(MOD_STEPS);

  // one RAM entry: {used, key, value}
  localparam int ENTRY_W          = 1 + KEY_W + VAL_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic clr;
    logic load;
    logic mod_step;
    logic set_home;
    logic advance;
    logic write;
    logic finish;
  } lphm_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic hit;
    logic empty;
    logic probe_last;
    logic is_lookup;
  } lphm_stat_t;

endpackage

### rtl/linear_probe_hash_map.sv
// From accept: the key remainder (MOD state), loading the home slot (HOME), then
// per probe a registered RAM read (READ) and a check (CHECK), then the result strobe.
// A new item is taken only when idle; one may start in the strobe cycle.
// Reset: synchronous; then a clearing pass writes every slot empty (busy high).
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module linear_probe_hash_map
  import lphm_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [VAL_W-1:0]      in_value,
  input  logic                  cfg_we,
  input  logic [SIZE_W-1:0]     cfg_wdata,
  output logic                  out_strobe,
  output logic [STATUS_W-1:0]   out_status,
  output logic [VAL_W-1:0]      out_found_value,
  output logic [SLOT_OUT_W-1:0] out_slot
);

  lphm_cmd_t  cmd;
  lphm_stat_t stat;

  lphm_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  lphm_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_command     (in_command),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_found_value(out_found_value),
    .out_slot       (out_slot)
  );

endmodule

### rtl/lphm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module lphm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/lphm_ctrl.sv
// Controller state machine for the hash map: clear pass, home slot, probe walk.
// Depends on lphm_pkg for the command and status structs.
`timescale 1ns / 1ps
module lphm_ctrl
  import lphm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  lphm_stat_t stat,
  output lphm_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HOME,
    S_READ,
    S_CHECK
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_done) begin
          state_nxt = S_HOME;
        end
      end
      S_HOME: begin
        cmd.set_home = 1'b1;
        state_nxt    = S_READ;
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.hit || stat.empty) begin
          cmd.write  = !stat.is_lookup;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else if (stat.probe_last) begin
          // every slot in use was visited: table full
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

### rtl/lphm_dp.sv
// Datapath for the hash map: size register, remainder unit, probe pointer,
// slot RAM and result registers. Depends on lphm_pkg and lphm_ram.
`timescale 1ns / 1ps
module lphm_dp
  import lphm_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lphm_cmd_t             cmd,
  output lphm_stat_t            stat,
  input  logic                  cfg_we,
  input  logic [SIZE_W-1:0]     cfg_wdata,
  input  logic                  in_command,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [VAL_W-1:0]      in_value,
  output logic                  out_strobe,
  output logic [STATUS_W-1:0]   out_status,
  output logic [VAL_W-1:0]      out_found_value,
  output logic [SLOT_OUT_W-1:0] out_slot
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int N_W    = $clog2(SLOTS + 1);

  logic [SIZE_W-1:0]    table_size_r;
  logic [N_W-1:0]       n_eff;
  logic [N_W-1:0]       n_r;
  logic                 cmd_r;
  logic [KEY_W-1:0]     key_r;
  logic [VAL_W-1:0]     val_r;
  logic [KEY_W-1:0]     div_sh_r, div_sh_nxt;
  logic [N_W-1:0]       rem_r, rem_nxt;
  logic [MOD_CNT_W-1:0] mod_cnt_r;
  logic [SLOT_W-1:0]    pos_r, pos_inc;
  logic [SLOT_W-1:0]    home_r;
  logic [N_W-1:0]       probes_r;
  logic [SLOT_W-1:0]    clr_addr_r;

  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic                 rd_used;
  logic [KEY_W-1:0]     rd_key;
  logic [VAL_W-1:0]     rd_val;
  logic                 hit, empty;
  logic [STATUS_W-1:0]  status_nxt;

  logic                  out_strobe_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [VAL_W-1:0]      out_found_value_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;

  // clamp the size register to 1..SLOTS
  always_comb begin
    logic [31:0] ts;
    ts = 32'(table_size_r);
    if (ts == 32'd0) begin
      n_eff = N_W'(1);
    end else if (ts > 32'(SLOTS)) begin
      n_eff = N_W'(SLOTS);
    end else begin
      n_eff = N_W'(ts);
    end
  end

  // restoring remainder, MOD_RADIX_BITS key bits per step
  always_comb begin
    logic [N_W:0]     t;
    logic [N_W-1:0]   r;
    logic [KEY_W-1:0] sh;
    r  = rem_r;
    sh = div_sh_r;
    for (int i = 0; i < MOD_RADIX_BITS; i++) begin
      t  = {r, sh[KEY_W-1]};
      sh = sh << 1;
      if (t >= {1'b0, n_r}) begin
        t = t - {1'b0, n_r};
      end
      r = t[N_W-1:0];
    end
    rem_nxt    = r;
    div_sh_nxt = sh;
  end

  // wrap at the effective size
  assign pos_inc = ((N_W'(pos_r) + N_W'(1)) == n_r) ? '0 : pos_r + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= SIZE_W'(TABLE_SIZE_RESET);
      clr_addr_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_size_r <= cfg_wdata;
      end
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + SLOT_W'(1);
      end
      out_strobe_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_command;
      key_r     <= in_key;
      val_r     <= in_value;
      div_sh_r  <= in_key;
      rem_r     <= '0;
      mod_cnt_r <= '0;
      n_r       <= n_eff;
    end
    if (cmd.mod_step) begin
      div_sh_r  <= div_sh_nxt;
      rem_r     <= rem_nxt;
      mod_cnt_r <= mod_cnt_r + MOD_CNT_W'(1);
    end
    if (cmd.set_home) begin
      pos_r    <= rem_r[SLOT_W-1:0];
      home_r   <= rem_r[SLOT_W-1:0];
      probes_r <= '0;
    end
    if (cmd.advance) begin
      pos_r    <= pos_inc;
      probes_r <= probes_r + N_W'(1);
    end
    if (cmd.finish) begin
      out_status_r      <= status_nxt;
      out_found_value_r <= (cmd_r == CMD_LOOKUP && hit) ? rd_val : '0;
      out_slot_r        <= (hit || empty) ? SLOT_OUT_W'(pos_r) : SLOT_OUT_W'(home_r);
    end
  end

  assign ram_we    = cmd.clr | cmd.write;
  assign ram_waddr = cmd.clr ? clr_addr_r : pos_r;
  assign ram_wdata = cmd.clr ? '0 : {1'b1, key_r, val_r};

  lphm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(pos_r),
    .rdata(ram_rdata)
  );

  assign rd_used = ram_rdata[ENTRY_W-1];
  assign rd_key  = ram_rdata[VAL_W +: KEY_W];
  assign rd_val  = ram_rdata[VAL_W-1:0];
  assign empty   = !rd_used;
  assign hit     = rd_used && (rd_key == key_r);

  always_comb begin
    if (hit || empty) begin
      status_nxt = (cmd_r == CMD_LOOKUP && !hit) ? ST_MISS : ST_OK;
    end else begin
      status_nxt = (cmd_r == CMD_LOOKUP) ? ST_MISS : ST_FULL;
    end
  end

  assign stat.clr_done   = (clr_addr_r == SLOT_W'(SLOTS - 1));
  assign stat.mod_done   = (mod_cnt_r == MOD_CNT_W'(MOD_STEPS - 1));
  assign stat.hit        = hit;
  assign stat.empty      = empty;
  assign stat.probe_last = (probes_r == (n_r - N_W'(1)));
  assign stat.is_lookup  = (cmd_r == CMD_LOOKUP);

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_value_r;
  assign out_slot        = out_slot_r;

endmodule

### rtl/lphm_checker.sv
// Port-level checks for linear_probe_hash_map, bound to the top level.
// Depends on lphm_pkg for status codes.
`timescale 1ns / 1ps
module lphm_checker
  import lphm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_strobe,
  input logic [STATUS_W-1:0]   out_status,
  input logic [VAL_W-1:0]      out_found_value
);

  // reset starts the clearing pass
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobed while still busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

  a_status_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_MISS || out_status == ST_FULL)) |->
      (out_found_value == '0))
    else $error("nonzero value with miss or full status");

endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (.*);

### tb/sv/lphm_checker.sv
// Scoreboard for linear_probe_hash_map: mirrors the slot table, predicts each item's result
// and compares it with the strobed result. Depends on lphm_pkg.
`timescale 1ns / 1ps
module lphm_scoreboard
  import lphm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_command,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [VAL_W-1:0]      in_value,
  input  logic                  cfg_we,
  input  logic [SIZE_W-1:0]     cfg_wdata,
  input  logic                  out_strobe,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic [VAL_W-1:0]      out_found_value,
  input  logic [SLOT_OUT_W-1:0] out_slot,
  output int                    outstanding,
  output int                    failures
);

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [VAL_W-1:0]      found_value;
    logic [SLOT_OUT_W-1:0] slot;
  } probe_result_t;

  logic [KEY_W-1:0]  stored_key   [DEFAULT_SLOTS];
  logic [VAL_W-1:0]  stored_value [DEFAULT_SLOTS];
  bit                occupied     [DEFAULT_SLOTS];
  logic [SIZE_W-1:0] active_size;

  probe_result_t pending_results[$];
  probe_result_t want, got;
  int            mismatch_count = 0;

  // Walk the table from the home slot and apply the item to the mirrored state.
  task automatic probe_table(input logic cmd, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val, output probe_result_t r);
    int unsigned n, home, pos, probes;
    bit hit, empty;
    n = (active_size == 0) ? 1 :
        (active_size > DEFAULT_SLOTS) ? DEFAULT_SLOTS : active_size;
    home  = key % n;
    pos   = home;
    hit   = 1'b0;
    empty = 1'b0;
    for (probes = 0; probes < n; probes++) begin
      if (!occupied[pos]) begin
        empty = 1'b1;
        break;
      end
      if (stored_key[pos] == key) begin
        hit = 1'b1;
        break;
      end
      pos = (pos + 1 == n) ? 0 : pos + 1;
    end
    // every slot visited without success: report at the home slot
    if (!hit && !empty) pos = home;
    r.found_value = '0;
    r.slot        = SLOT_OUT_W'(pos);
    if (cmd == CMD_INSERT) begin
      if (hit || empty) begin
        occupied[pos]     = 1'b1;
        stored_key[pos]   = key;
        stored_value[pos] = val;
        r.status          = ST_OK;
      end else begin
        r.status = ST_FULL;
      end
    end else if (hit) begin
      r.found_value = stored_value[pos];
      r.status      = ST_OK;
    end else begin
      r.status = ST_MISS;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (occupied[i]) occupied[i] = 1'b0;
      active_size = SIZE_W'(TABLE_SIZE_RESET);
      pending_results.delete();
    end else begin
      if (cfg_we) active_size = cfg_wdata;
      if (out_strobe) begin
        got = '{status: out_status, found_value: out_found_value, slot: out_slot};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d value %h slot %0d",
                   $time, got.status, got.found_value, got.slot);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            mismatch_count++;
          end
          if (got.found_value !== want.found_value) begin
            $display("%0t: found_value expected %h, got %h",
                     $time, want.found_value, got.found_value);
            mismatch_count++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: slot expected %0d, got %0d", $time, want.slot, got.slot);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        probe_table(in_command, in_key, in_value, want);
        pending_results.push_back(want);
      end
    end
    outstanding <= pending_results.size();
    failures    <= mismatch_count;
  end

endmodule

### tb/sv/tb_top.sv
// Top of the linear_probe_hash_map regression: clock, reset, item and size stimulus, verdict.
// Depends on lphm_pkg, linear_probe_hash_map and lphm_scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import lphm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_command = CMD_INSERT;
  logic [KEY_W-1:0]      in_key = '0;
  logic [VAL_W-1:0]      in_value = '0;
  logic                  cfg_we = 1'b0;
  logic [SIZE_W-1:0]     cfg_wdata = '0;
  logic                  out_strobe;
  logic [STATUS_W-1:0]   out_status;
  logic [VAL_W-1:0]      out_found_value;
  logic [SLOT_OUT_W-1:0] out_slot;
  int                    outstanding;
  int                    failures;

  logic [KEY_W-1:0] key_pool[$];
  int               burst_left = 4;
  int               gap_max = 3;
  logic [SIZE_W-1:0] phase_sizes[10] = '{1, 3, 16, 37, 100, 1023, 0, 260, 512, 64};

  linear_probe_hash_map dut (
    .clk, .rst_n, .start, .busy, .in_command, .in_key, .in_value,
    .cfg_we, .cfg_wdata, .out_strobe, .out_status, .out_found_value, .out_slot
  );

  lphm_scoreboard u_scoreboard (
    .clk, .rst_n, .start, .busy, .in_command, .in_key, .in_value,
    .cfg_we, .cfg_wdata, .out_strobe, .out_status, .out_found_value, .out_slot,
    .outstanding, .failures
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hold the item until the block takes it, then maybe open a gap.
  task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val);
    start      <= 1'b1;
    in_command <= cmd;
    in_key     <= key;
    in_value   <= val;
    do @(posedge clk); while (busy);
    if (cmd == CMD_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > 64) void'(key_pool.pop_front());
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  // Stop sending and wait for every pending result and an idle block.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] size);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int pool_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (key_pool.size() != 0 && r < pool_pct)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (r < pool_pct + 12) return KEY_W'($urandom_range(0, 2047));
    if (r < pool_pct + 16) return r[0] ? '1 : '0;
    return $urandom;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  initial begin
    logic cmd;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, key zero, wrap, overwrite, size extremes, full table
    send_item(CMD_LOOKUP, 32'h0, 32'h0);
    send_item(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_item(CMD_LOOKUP, 32'h0, 32'h0);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_INSERT, 32'd511, 32'hA5A5_5A5A);
    send_item(CMD_LOOKUP, 32'd511, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'h0, 32'h1234_5678);
    send_item(CMD_LOOKUP, 32'h0, 32'h0);
    send_item(CMD_LOOKUP, 32'd512, 32'h0);
    write_size(10'd0);
    send_item(CMD_LOOKUP, 32'd7, 32'h0);
    send_item(CMD_INSERT, 32'd7, 32'h7777_7777);
    send_item(CMD_LOOKUP, 32'h0, 32'h0);
    send_item(CMD_INSERT, 32'h0, 32'hDEAD_BEEF);
    write_size(10'd1023);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    write_size(10'd2);
    send_item(CMD_INSERT, 32'd3, 32'h3333_3333);
    send_item(CMD_LOOKUP, 32'd511, 32'h0);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    write_size(10'd4);
    send_item(CMD_INSERT, 32'd6, 32'h6666_6666);
    send_item(CMD_INSERT, 32'd3, 32'h3030_3030);
    send_item(CMD_INSERT, 32'd7, 32'h7070_7070);
    send_item(CMD_LOOKUP, 32'd7, 32'h0);
    send_item(CMD_LOOKUP, 32'd3, 32'h0);

    phase_sizes[9] = SIZE_W'($urandom_range(1, 1023));
    foreach (phase_sizes[p]) begin
      write_size(phase_sizes[p]);
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 6;
        default: gap_max = 25;
      endcase
      repeat (75) begin
        cmd = ($urandom_range(0, 99) < 50) ? CMD_LOOKUP : CMD_INSERT;
        send_item(cmd, pick_key(cmd == CMD_LOOKUP ? 60 : 25), pick_value());
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("linear_probe_hash_map regression: pass");
    end else begin
      $display("linear_probe_hash_map regression: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("linear_probe_hash_map regression: fail");
    $finish;
  end

endmodule

### sim.f
rtl/lphm_pkg.sv
rtl/lphm_ram.sv
rtl/lphm_ctrl.sv
rtl/lphm_dp.sv
rtl/linear_probe_hash_map.sv
rtl/lphm_checker.sv
tb/sv/lphm_checker.sv
tb/sv/tb_top.sv
